// ===== rtl/core/wiss_pkg.sv =====
// Shared types and constants for the information-element security summary block.
// No dependencies.
package wiss_pkg;

	localparam logic [7:0] ID_VENDOR  = 8'd221;
	localparam logic [7:0] ID_RSN     = 8'd48;
	localparam logic [7:0] ID_HT_OP   = 8'd61;
	localparam logic [7:0] ID_VHT_OP  = 8'd192;
	localparam logic [7:0] ID_VHT_CAP = 8'd191;
	localparam logic [7:0] ID_HT_CAP  = 8'd45;
	localparam logic [7:0] ID_HE_CAP  = 8'd232;
	localparam logic [7:0] ID_EHT_CAP = 8'd255;

	localparam logic [15:0] CAP_PRIVACY = 16'h0010;
	localparam logic [15:0] CAP_ESS     = 16'h0001;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW    = 1;

	typedef enum logic [1:0] {
		PH_ID  = 2'd0,
		PH_LEN = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		SS_HDR    = 3'd0,
		SS_PCNT   = 3'd1,
		SS_PSUITE = 3'd2,
		SS_ACNT   = 3'd3,
		SS_ASUITE = 3'd4,
		SS_DONE   = 3'd5
	} sec_stage_t;

	// Raw per-buffer state handed from the parser to the result stage
	typedef struct packed {
		logic        rsn_present;
		logic [7:0]  rsn_akm;
		logic [6:0]  rsn_cipher;
		logic        wpa_present;
		logic [7:0]  wpa_akm;
		logic [6:0]  wpa_cipher;
		logic        ht40;
		logic        vht_valid;
		logic [7:0]  vht_w;
		logic [7:0]  vht_s0;
		logic [7:0]  vht_s1;
		logic [3:0]  std_seen; // eht, he, vht cap, ht cap
		logic [15:0] cap;
	} summ_raw_t;

	function automatic logic [6:0] cipher_bit(input logic [7:0] t);
		logic [6:0] r;
		r = '0;
		case (t)
			8'd1: r = 7'h01;
			8'd2: r = 7'h02;
			8'd4: r = 7'h04;
			8'd5: r = 7'h08;
			8'd8: r = 7'h10;
			8'd9: r = 7'h20;
			8'd10: r = 7'h40;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] akm_bit(input logic [7:0] t);
		logic [7:0] r;
		r = '0;
		case (t)
			8'd1: r = 8'h01;
			8'd2: r = 8'h02;
			8'd3: r = 8'h04;
			8'd4: r = 8'h08;
			8'd5: r = 8'h10;
			8'd6: r = 8'h20;
			8'd8: r = 8'h40;
			8'd9: r = 8'h80;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] wpa_prefix(input logic [1:0] i);
		logic [7:0] r;
		r = '0;
		case (i)
			2'd0: r = 8'h00;
			2'd1: r = 8'h50;
			2'd2: r = 8'hf2;
			2'd3: r = 8'h01;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/wlan_ie_security_summary_unit.sv =====
// Information-element security summary: one byte per cycle in, one summary per buffer out.
// Bytes are accepted every cycle unless full is high; full rises only when the two-entry
// summary queue and the output register all hold results not yet popped. A summary
// is written into the queue with the final byte and then moves into the output register;
// it waits in the queue only while earlier summaries are still waiting to be popped.
module wlan_ie_security_summary_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  ie_byte,
	input  logic        end_of_buffer,
	input  logic [15:0] capability_info,
	output logic        empty,
	input  logic        pop,
	output logic        rsn_present,
	output logic [7:0]  rsn_akm_mask,
	output logic [6:0]  rsn_cipher_mask,
	output logic        wpa_present,
	output logic [7:0]  wpa_akm_mask,
	output logic [6:0]  wpa_cipher_mask,
	output logic        privacy_wep,
	output logic        ess_flag,
	output logic [2:0]  channel_width,
	output logic [10:0] center_freq0,
	output logic [10:0] center_freq1,
	output logic [2:0]  wifi_standard
);

	wiss_pkg::summ_raw_t raw, qd;
	logic                done, qfull, qempty, qrd, take;

	assign full = qfull;
	assign take = push && !qfull;

	wiss_parse u_parse (
		.clk, .arst_n, .take, .ie_byte, .end_of_buffer, .capability_info,
		.done, .raw
	);

	wiss_queue u_queue (
		.clk, .arst_n, .wr(done), .wdata(raw), .full(qfull), .empty(qempty),
		.rd(qrd), .rdata(qd)
	);

	wiss_result u_result (
		.clk, .arst_n, .q_empty(qempty), .q_data(qd), .q_rd(qrd), .empty, .pop,
		.rsn_present, .rsn_akm_mask, .rsn_cipher_mask, .wpa_present, .wpa_akm_mask,
		.wpa_cipher_mask, .privacy_wep, .ess_flag, .channel_width, .center_freq0,
		.center_freq1, .wifi_standard
	);

endmodule

// ===== rtl/core/wiss_parse.sv =====
// Front part: walks element records byte by byte and gathers raw summary state.
// Depends on wiss_pkg.
module wiss_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          ie_byte,
	input  logic                end_of_buffer,
	input  logic [15:0]         capability_info,
	output logic                done,
	output wiss_pkg::summ_raw_t raw
);

	wiss_pkg::phase_t     phase_q, phase_d;
	logic [7:0]           id_q, id_d, len_q, len_d, off_q, off_d, seen_q, seen_d;
	wiss_pkg::sec_stage_t stage_q, stage_d;
	logic [1:0]           sbytes_q, sbytes_d;
	logic [2:0]           hbytes_q, hbytes_d;
	logic [15:0]          cnt_q, cnt_d, idx_q, idx_d;
	logic [7:0]           pakm_q, pakm_d;
	logic [6:0]           pcip_q, pcip_d;
	logic                 pval_q, pval_d, oui_q, oui_d;
	logic [7:0]           ht_q, ht_d, vw_q, vw_d, vs0_q, vs0_d, vs1_q, vs1_d;
	wiss_pkg::summ_raw_t  acc_q, acc_d, fin;
	logic [7:0]           seen_f;

	// Next state of the record walker
	always_comb begin
		logic feed, commit;
		logic [15:0] idx_n;
		feed = 1'b0;
		commit = 1'b0;
		idx_n = '0;
		phase_d = phase_q; id_d = id_q; len_d = len_q; off_d = off_q; seen_d = seen_q;
		stage_d = stage_q; sbytes_d = sbytes_q; hbytes_d = hbytes_q;
		cnt_d = cnt_q; idx_d = idx_q; pakm_d = pakm_q; pcip_d = pcip_q;
		pval_d = pval_q; oui_d = oui_q; ht_d = ht_q; vw_d = vw_q; vs0_d = vs0_q;
		vs1_d = vs1_q; acc_d = acc_q;
		case (phase_q)
			wiss_pkg::PH_ID: begin
				id_d = ie_byte;
				phase_d = wiss_pkg::PH_LEN;
			end
			wiss_pkg::PH_LEN: begin
				len_d = ie_byte; off_d = '0;
				stage_d = wiss_pkg::SS_HDR; sbytes_d = '0; hbytes_d = '0;
				cnt_d = '0; idx_d = '0; pakm_d = '0; pcip_d = '0; pval_d = 1'b0;
				oui_d = 1'b1; ht_d = '0; vw_d = '0; vs0_d = '0; vs1_d = '0;
				if (ie_byte == 8'd0) begin
					commit = 1'b1;
					phase_d = wiss_pkg::PH_ID;
				end else begin
					phase_d = wiss_pkg::PH_BODY;
				end
			end
			default: begin
				if (id_q == wiss_pkg::ID_HT_OP && off_q == 8'd1) ht_d = ie_byte;
				if (id_q == wiss_pkg::ID_VHT_OP) begin
					if (off_q == 8'd0) vw_d = ie_byte;
					else if (off_q == 8'd1) vs0_d = ie_byte;
					else if (off_q == 8'd2) vs1_d = ie_byte;
				end
				if (id_q == wiss_pkg::ID_RSN && !seen_q[0]) feed = 1'b1;
				if (id_q == wiss_pkg::ID_VENDOR) begin
					if (off_q < 8'd4) begin
						if (ie_byte != wiss_pkg::wpa_prefix(off_q[1:0])) oui_d = 1'b0;
					end else if (oui_q) begin
						feed = 1'b1;
					end
				end
				off_d = off_q + 8'd1;
				if (off_d >= len_q) begin
					commit = 1'b1;
					phase_d = wiss_pkg::PH_ID;
				end
			end
		endcase

		// Advance the security suite parser by one byte
		if (feed) begin
			case (stage_q)
				wiss_pkg::SS_HDR: begin
					if (hbytes_q == 3'd5) begin
						stage_d = wiss_pkg::SS_PCNT; hbytes_d = '0;
					end else begin
						hbytes_d = hbytes_q + 3'd1;
					end
				end
				wiss_pkg::SS_PCNT, wiss_pkg::SS_ACNT: begin
					if (sbytes_q == 2'd0) begin
						cnt_d = {8'd0, ie_byte}; sbytes_d = 2'd1;
					end else begin
						cnt_d = {ie_byte, cnt_q[7:0]};
						idx_d = '0; sbytes_d = '0;
						if (stage_q == wiss_pkg::SS_ACNT) pval_d = 1'b1;
						if (cnt_d == 16'd0)
							stage_d = wiss_pkg::sec_stage_t'(stage_q + 3'd2);
						else
							stage_d = wiss_pkg::sec_stage_t'(stage_q + 3'd1);
					end
				end
				wiss_pkg::SS_PSUITE, wiss_pkg::SS_ASUITE: begin
					if (sbytes_q == 2'd3) begin
						if (stage_q == wiss_pkg::SS_PSUITE)
							pcip_d = pcip_q | wiss_pkg::cipher_bit(ie_byte);
						else
							pakm_d = pakm_q | wiss_pkg::akm_bit(ie_byte);
						idx_n = idx_q + 16'd1;
						idx_d = idx_n; sbytes_d = '0;
						if (idx_n == cnt_q)
							stage_d = wiss_pkg::sec_stage_t'(stage_q + 3'd1);
					end else begin
						sbytes_d = sbytes_q + 2'd1;
					end
				end
				default: ;
			endcase
		end

		// Fold a completed record into the summary
		if (commit) begin
			case (id_d)
				wiss_pkg::ID_RSN: if (!seen_q[0]) begin
					seen_d[0] = 1'b1;
					if (pval_d) begin
						acc_d.rsn_present = 1'b1;
						acc_d.rsn_akm = pakm_d;
						acc_d.rsn_cipher = pcip_d;
					end
				end
				wiss_pkg::ID_VENDOR: if (len_d >= 8'd4 && oui_d && pval_d) begin
					acc_d.wpa_present = 1'b1;
					acc_d.wpa_akm = acc_q.wpa_akm | pakm_d;
					acc_d.wpa_cipher = acc_q.wpa_cipher | pcip_d;
				end
				wiss_pkg::ID_HT_OP: if (!seen_q[1]) begin
					seen_d[1] = 1'b1;
					if (len_d >= 8'd2 && ht_d[3:2] != 2'd0) acc_d.ht40 = 1'b1;
				end
				wiss_pkg::ID_VHT_OP: if (!seen_q[2]) begin
					seen_d[2] = 1'b1;
					if (len_d >= 8'd3) begin
						acc_d.vht_valid = 1'b1;
						acc_d.vht_w = vw_d; acc_d.vht_s0 = vs0_d; acc_d.vht_s1 = vs1_d;
					end
				end
				wiss_pkg::ID_EHT_CAP: seen_d[3] = 1'b1;
				wiss_pkg::ID_HE_CAP:  seen_d[4] = 1'b1;
				wiss_pkg::ID_VHT_CAP: seen_d[5] = 1'b1;
				wiss_pkg::ID_HT_CAP:  seen_d[6] = 1'b1;
				default: ;
			endcase
		end
	end

	// Form the finished buffer summary
	assign seen_f = seen_d;
	always_comb begin
		fin = acc_d;
		fin.std_seen = {seen_f[3], seen_f[4], seen_f[5], seen_f[6]};
		fin.cap = capability_info;
	end
	assign raw  = fin;
	assign done = take && end_of_buffer;

	// Hold walker state; clear it at buffer end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wiss_pkg::PH_ID; id_q <= '0; len_q <= '0; off_q <= '0; seen_q <= '0;
			stage_q <= wiss_pkg::SS_HDR; sbytes_q <= '0; hbytes_q <= '0;
			cnt_q <= '0; idx_q <= '0; pakm_q <= '0; pcip_q <= '0; pval_q <= 1'b0;
			oui_q <= 1'b0; ht_q <= '0; vw_q <= '0; vs0_q <= '0; vs1_q <= '0; acc_q <= '0;
		end else if (take) begin
			if (end_of_buffer) begin
				phase_q <= wiss_pkg::PH_ID; id_q <= '0; len_q <= '0; off_q <= '0;
				seen_q <= '0; stage_q <= wiss_pkg::SS_HDR; sbytes_q <= '0;
				hbytes_q <= '0; cnt_q <= '0; idx_q <= '0; pakm_q <= '0; pcip_q <= '0;
				pval_q <= 1'b0; oui_q <= 1'b0; ht_q <= '0; vw_q <= '0; vs0_q <= '0;
				vs1_q <= '0; acc_q <= '0;
			end else begin
				phase_q <= phase_d; id_q <= id_d; len_q <= len_d; off_q <= off_d;
				seen_q <= seen_d; stage_q <= stage_d; sbytes_q <= sbytes_d;
				hbytes_q <= hbytes_d; cnt_q <= cnt_d; idx_q <= idx_d; pakm_q <= pakm_d;
				pcip_q <= pcip_d; pval_q <= pval_d; oui_q <= oui_d; ht_q <= ht_d;
				vw_q <= vw_d; vs0_q <= vs0_d; vs1_q <= vs1_d; acc_q <= acc_d;
			end
		end
	end

endmodule

// ===== rtl/core/wiss_queue.sv =====
// Short queue of raw summaries between parser and result stage.
// Depends on wiss_pkg.
module wiss_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  wiss_pkg::summ_raw_t wdata,
	output logic                full,
	output logic                empty,
	input  logic                rd,
	output wiss_pkg::summ_raw_t rdata
);

	wiss_pkg::summ_raw_t          mem_q [wiss_pkg::QDEPTH];
	logic [wiss_pkg::QAW-1:0]     wp_q, rp_q;
	logic [wiss_pkg::QAW:0]       cnt_q;

	assign full  = cnt_q == (wiss_pkg::QAW+1)'(wiss_pkg::QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 1'b1;
			if (rd && !empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (wiss_pkg::QAW+1)'(wr && !full) - (wiss_pkg::QAW+1)'(rd && !empty);
		end
	end

endmodule

// ===== rtl/core/wiss_result.sv =====
// Back part: turns a raw summary into result fields and holds them in an output register.
// Depends on wiss_pkg.
module wiss_result (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  wiss_pkg::summ_raw_t q_data,
	output logic                q_rd,
	output logic                empty,
	input  logic                pop,
	output logic                rsn_present,
	output logic [7:0]          rsn_akm_mask,
	output logic [6:0]          rsn_cipher_mask,
	output logic                wpa_present,
	output logic [7:0]          wpa_akm_mask,
	output logic [6:0]          wpa_cipher_mask,
	output logic                privacy_wep,
	output logic                ess_flag,
	output logic [2:0]          channel_width,
	output logic [10:0]         center_freq0,
	output logic [10:0]         center_freq1,
	output logic [2:0]          wifi_standard
);

	logic        vld_q;
	logic [2:0]  w;
	logic [7:0]  s0, s1;
	logic [2:0]  std_lvl;
	logic        load;

	assign load = !q_empty && (!vld_q || pop);
	assign q_rd = load;
	assign empty = !vld_q;

	// Work out width, segments and standard level
	always_comb begin
		w = q_data.ht40 ? 3'd1 : 3'd0;
		s0 = '0;
		s1 = '0;
		if (q_data.vht_valid) begin
			if (q_data.vht_w == 8'd1) begin
				w = 3'd2; s0 = q_data.vht_s0;
			end else if (q_data.vht_w == 8'd2) begin
				w = 3'd3; s0 = q_data.vht_s1;
			end else if (q_data.vht_w == 8'd3 && q_data.vht_s0 != 8'd0 &&
				q_data.vht_s1 != 8'd0) begin
				w = 3'd4; s0 = q_data.vht_s0; s1 = q_data.vht_s1;
			end
		end
		if (q_data.std_seen[3]) std_lvl = 3'd4;
		else if (q_data.std_seen[2]) std_lvl = 3'd3;
		else if (q_data.std_seen[1]) std_lvl = 3'd2;
		else if (q_data.std_seen[0]) std_lvl = 3'd1;
		else std_lvl = 3'd0;
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (load) begin
			rsn_present     <= q_data.rsn_present;
			rsn_akm_mask    <= q_data.rsn_present ? q_data.rsn_akm : 8'd0;
			rsn_cipher_mask <= q_data.rsn_present ? q_data.rsn_cipher : 7'd0;
			wpa_present     <= q_data.wpa_present;
			wpa_akm_mask    <= q_data.wpa_akm;
			wpa_cipher_mask <= q_data.wpa_cipher;
			privacy_wep     <= !q_data.rsn_present && !q_data.wpa_present &&
				((q_data.cap & wiss_pkg::CAP_PRIVACY) != 16'd0);
			ess_flag        <= (q_data.cap & wiss_pkg::CAP_ESS) != 16'd0;
			channel_width   <= w;
			center_freq0    <= {1'b0, s0, 2'b00} + {3'd0, s0};
			center_freq1    <= {1'b0, s1, 2'b00} + {3'd0, s1};
			wifi_standard   <= std_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (load) vld_q <= 1'b1;
		else if (pop) vld_q <= 1'b0;
	end

endmodule

// ===== rtl/core/wiss_checker.sv =====
// Port-level checks on the summary unit, bound to the top level.
// Depends on wlan_ie_security_summary_unit.
module wiss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        rsn_present,
	input logic [7:0]  rsn_akm_mask,
	input logic        privacy_wep,
	input logic        wpa_present,
	input logic [2:0]  channel_width,
	input logic [10:0] center_freq1,
	input logic [2:0]  wifi_standard
);

	// Hold a waiting result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result dropped");

	a_rsnmask: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !rsn_present |-> rsn_akm_mask == 8'd0) else $error("rsn mask");

	a_wep: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && privacy_wep |-> !rsn_present && !wpa_present) else $error("wep");

	a_cf1: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && channel_width != 3'd4 |-> center_freq1 == 11'd0) else $error("cf1");

	a_rng: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> channel_width <= 3'd4 && wifi_standard <= 3'd4) else $error("range");

endmodule

bind wlan_ie_security_summary_unit wiss_checker u_chk (
	.clk, .arst_n, .empty, .pop, .rsn_present, .rsn_akm_mask, .privacy_wep,
	.wpa_present, .channel_width, .center_freq1, .wifi_standard
);
